// File: src/tpfm_pkg.sv
// shared types, constants and helpers for the two-channel phase and frequency meter
package tpfm_pkg;

   // default counter width, field widths and configuration reset values
   localparam int DEFAULT_COUNTER_WIDTH = 16;
   localparam int CLOCK_HZ_WIDTH = 27;
   localparam int LATENCY_WIDTH = 10;
   localparam int RELOAD_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 27;
   localparam int PHASE_WIDTH = 12;
   localparam int PERIOD_OUT_WIDTH = 17;

   localparam logic [CLOCK_HZ_WIDTH-1:0] CLOCK_HZ_RESET = 27'd72000000;
   localparam logic [LATENCY_WIDTH-1:0] LATENCY_RESET = 10'd117;
   localparam logic [RELOAD_WIDTH-1:0] RELOAD_RESET = 16'd65535;

   // phase scale: full turn, half turn and the saturation point before wrap
   localparam int PHASE_FULL = 3600;
   localparam int PHASE_HALF = 1800;
   localparam int PHASE_SAT_LIMIT = 5400;
   localparam int PHASE_SCALE_WIDTH = 12;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TIMER_CLOCK_HZ = 2'd0,
      CSR_LATENCY_COMP   = 2'd1,
      CSR_RELOAD_VALUE   = 2'd2
   } csr_index_type;

   // request and response payloads
   typedef struct packed {
      logic ref_edge;
      logic sig_edge;
   } req_type;

   typedef struct packed {
      logic signed [PHASE_WIDTH-1:0] phase_tenths_deg;
      logic [CLOCK_HZ_WIDTH-1:0] frequency_hz;
      logic [PERIOD_OUT_WIDTH-1:0] period_ticks;
   } rsp_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // compensated capture width: count plus one plus the latency term
   function automatic int tick_width(input int counter_width);
      tick_width = ((counter_width > LATENCY_WIDTH) ? counter_width : LATENCY_WIDTH) + 1;
   endfunction

   // divider numerator width: scaled delay or the clock rate, whichever is wider
   function automatic int num_width(input int counter_width);
      int scaled;
      scaled = tick_width(counter_width) + PHASE_SCALE_WIDTH;
      num_width = (scaled > CLOCK_HZ_WIDTH) ? scaled : CLOCK_HZ_WIDTH;
   endfunction

endpackage

// File: src/tpfm_capture.sv
// free-running tick counter, arming and compensated edge captures
module tpfm_capture #(
   parameter int COUNTER_WIDTH = tpfm_pkg::DEFAULT_COUNTER_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  tpfm_pkg::req_type req,
   input  logic [tpfm_pkg::LATENCY_WIDTH-1:0] latency_comp,
   input  logic [tpfm_pkg::RELOAD_WIDTH-1:0] reload_value,
   output logic measure_fire,
   output logic [tpfm_pkg::tick_width(COUNTER_WIDTH)-1:0] period_comp,
   output logic [tpfm_pkg::tick_width(COUNTER_WIDTH)-1:0] delay_comp
);
   import tpfm_pkg::*;

   localparam int TickWidth = tick_width(COUNTER_WIDTH);
   localparam int CmpWidth = (COUNTER_WIDTH > RELOAD_WIDTH) ? COUNTER_WIDTH : RELOAD_WIDTH;

   logic [COUNTER_WIDTH-1:0] count_ff, count_in;
   logic [COUNTER_WIDTH-1:0] sig_cap_ff, sig_cap_in;
   logic armed_ff, armed_in;
   logic [TickWidth-1:0] period_ff, period_in;
   logic [TickWidth-1:0] delay_ff, delay_in;
   logic arm_now;
   logic at_reload;

   // one tick: signal latch first, then arm or complete, then advance
   always_comb begin
      sig_cap_in = sig_cap_ff;
      armed_in = armed_ff;
      count_in = count_ff;
      period_in = period_ff;
      delay_in = delay_ff;
      arm_now = req.ref_edge && !armed_ff;
      at_reload = CmpWidth'(count_ff) >= CmpWidth'(reload_value);
      measure_fire = accept && req.ref_edge && armed_ff;
      if (accept) begin
         if (req.sig_edge) begin
            sig_cap_in = count_ff;
         end
         if (req.ref_edge) begin
            armed_in = !armed_ff;
         end
         if (arm_now || at_reload) begin
            count_in = '0;
         end else begin
            count_in = count_ff + COUNTER_WIDTH'(1);
         end
      end
      // compensate both captures when a measurement completes
      if (measure_fire) begin
         period_in = TickWidth'(count_ff) + TickWidth'(1) + TickWidth'(latency_comp);
         delay_in = TickWidth'(sig_cap_in) + TickWidth'(1) + TickWidth'(latency_comp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sig_cap_ff <= '0;
         armed_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sig_cap_ff <= sig_cap_in;
         armed_ff <= armed_in;
      end
   end

   // captured values, no reset needed
   always_ff @(posedge clock) begin
      period_ff <= period_in;
      delay_ff <= delay_in;
   end

   assign period_comp = period_ff;
   assign delay_comp = delay_ff;

endmodule

// File: src/tpfm_divider.sv
// shared restoring divider, one quotient bit per cycle
module tpfm_divider #(
   parameter int NUM_WIDTH = 29,
   parameter int DEN_WIDTH = 17
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NUM_WIDTH-1:0] numerator,
   input  logic [DEN_WIDTH-1:0] denominator,
   output tpfm_pkg::div_status_type status,
   output logic [NUM_WIDTH-1:0] quotient
);
   import tpfm_pkg::*;

   localparam int StepWidth = $clog2(NUM_WIDTH + 1);
   localparam logic [StepWidth-1:0] LastStep = StepWidth'(NUM_WIDTH - 1);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [DEN_WIDTH:0] shifted;
   logic [DEN_WIDTH:0] diff;
   logic fits;

   // shift in one numerator bit, subtract when the divisor fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      shifted = {rem_ff, acc_ff[NUM_WIDTH-1]};
      diff = shifted - {1'b0, den_ff};
      fits = shifted >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in = numerator;
         rem_in = '0;
         den_in = denominator;
      end else if (busy_ff) begin
         acc_in = {acc_ff[NUM_WIDTH-2:0], fits};
         rem_in = fits ? diff[DEN_WIDTH-1:0] : shifted[DEN_WIDTH-1:0];
         step_in = step_ff + StepWidth'(1);
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = acc_ff;

endmodule

// File: src/two_channel_phase_frequency_meter.sv
// top level: configuration registers, measurement sequencer and response register
//
//   channel  ports                             moves
//   req      req_valid req_ready req_data      one timer tick with both edge flags
//   rsp      rsp_valid rsp_ready rsp_data      phase, frequency and period of one cycle
//   csr      csr_wr_en csr_index csr_wdata     register write, no wait, no read-back
//
// a tick that does not complete a measurement leaves req_ready high; one that does
// holds req_ready low while the shared divider runs phase and then frequency.
// reset is synchronous and needs no clearing pass. a waiting response stalls the
// sequencer only at its last step; ticks flow while it is held and the block is idle.
module two_channel_phase_frequency_meter #(
   parameter int COUNTER_WIDTH = tpfm_pkg::DEFAULT_COUNTER_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  tpfm_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tpfm_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [tpfm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tpfm_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import tpfm_pkg::*;

   localparam int TickWidth = tick_width(COUNTER_WIDTH);
   localparam int NumWidth = num_width(COUNTER_WIDTH);
   localparam int PeriodWide = (TickWidth > PERIOD_OUT_WIDTH) ? TickWidth : PERIOD_OUT_WIDTH;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_PGO   = 7'b0001000,
      ST_PDIV  = 7'b0010000,
      ST_FDIV  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CLOCK_HZ_WIDTH-1:0] clock_hz_ff, clock_hz_in;
   logic [LATENCY_WIDTH-1:0] latency_ff, latency_in;
   logic [RELOAD_WIDTH-1:0] reload_ff, reload_in;
   logic [TickWidth-1:0] delay_adj_ff, delay_adj_in;
   logic [NumWidth-1:0] num_ff, num_in;
   logic wrap_ff, wrap_in;
   logic signed [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [CLOCK_HZ_WIDTH-1:0] freq_ff, freq_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic measure_fire;
   logic [TickWidth-1:0] period_comp;
   logic [TickWidth-1:0] delay_comp;
   logic div_start;
   logic [NumWidth-1:0] div_num;
   div_status_type div_status;
   logic [NumWidth-1:0] div_quot;
   logic [PHASE_WIDTH:0] phase_shift;
   logic signed [PHASE_WIDTH-1:0] phase_calc;
   logic [PeriodWide-1:0] period_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   // configuration writes
   always_comb begin
      clock_hz_in = clock_hz_ff;
      latency_in = latency_ff;
      reload_in = reload_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TIMER_CLOCK_HZ: clock_hz_in = csr_wdata[CLOCK_HZ_WIDTH-1:0];
            CSR_LATENCY_COMP:   latency_in = csr_wdata[LATENCY_WIDTH-1:0];
            CSR_RELOAD_VALUE:   reload_in = csr_wdata[RELOAD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   tpfm_capture #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_capture (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .latency_comp(latency_ff),
      .reload_value(reload_ff),
      .measure_fire(measure_fire),
      .period_comp(period_comp),
      .delay_comp(delay_comp)
   );

   // divider shared between phase and frequency
   assign div_start = (state_ff == ST_PGO) || ((state_ff == ST_PDIV) && div_status.done);
   assign div_num = (state_ff == ST_PGO) ? num_ff : NumWidth'(clock_hz_ff);

   tpfm_divider #(
      .NUM_WIDTH(NumWidth),
      .DEN_WIDTH(TickWidth)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numerator(div_num),
      .denominator(period_comp),
      .status(div_status),
      .quotient(div_quot)
   );

   // phase from the quotient: wrap into the negative half, saturate a stale capture
   always_comb begin
      phase_shift = div_quot[PHASE_WIDTH:0] - (PHASE_WIDTH + 1)'(PHASE_FULL);
      if (!wrap_ff) begin
         phase_calc = div_quot[PHASE_WIDTH-1:0];
      end else if (div_quot > NumWidth'(PHASE_SAT_LIMIT)) begin
         phase_calc = PHASE_WIDTH'(PHASE_HALF);
      end else begin
         phase_calc = phase_shift[PHASE_WIDTH-1:0];
      end
   end

   assign period_wide = PeriodWide'(period_comp);

   // measurement sequencer
   always_comb begin
      state_in = state_ff;
      delay_adj_in = delay_adj_ff;
      num_in = num_ff;
      wrap_in = wrap_ff;
      phase_in = phase_ff;
      freq_in = freq_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (measure_fire) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // take the period off a delay longer than the period
            delay_adj_in = (delay_comp > period_comp) ? (delay_comp - period_comp) : delay_comp;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            num_in = NumWidth'(delay_adj_ff) * NumWidth'(PHASE_FULL);
            wrap_in = {delay_adj_ff, 1'b0} > {1'b0, period_comp};
            state_in = ST_PGO;
         end
         ST_PGO: begin
            state_in = ST_PDIV;
         end
         ST_PDIV: begin
            if (div_status.done) begin
               phase_in = phase_calc;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (div_status.done) begin
               freq_in = div_quot[CLOCK_HZ_WIDTH-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.phase_tenths_deg = phase_ff;
               rsp_in.frequency_hz = freq_ff;
               rsp_in.period_ticks = period_wide[PERIOD_OUT_WIDTH-1:0];
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clock_hz_ff <= CLOCK_HZ_RESET;
         latency_ff <= LATENCY_RESET;
         reload_ff <= RELOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clock_hz_ff <= clock_hz_in;
         latency_ff <= latency_in;
         reload_ff <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_adj_ff <= delay_adj_in;
      num_ff <= num_in;
      wrap_ff <= wrap_in;
      phase_ff <= phase_in;
      freq_ff <= freq_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // divider is never restarted while it is still iterating
   a_start_idle_divider: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // a response leaving the sequencer is valid next cycle and the block is idle again
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response load did not return to idle");

   // delivered phase stays within half a turn either way
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.phase_tenths_deg >= -PHASE_WIDTH'(PHASE_HALF) &&
                        rsp_ff.phase_tenths_deg <= PHASE_WIDTH'(PHASE_HALF)))
      else $error("phase out of range");

   // a completing tick always leaves idle on the next cycle
   a_fire_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      measure_fire |=> (state_ff == ST_PREP))
      else $error("measurement not started");

endmodule
